FILE: rtl/dws_pkg.sv
package dws_pkg;

   // ring geometry
   localparam int DEPTH    = 16;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int OCC_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = OCC_W + 1;
   localparam int WORD_W   = 32;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_REAR  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_REAR   = 3'd3,
      MODE_SEARCH     = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // base + off, wrapped into the ring; off never exceeds DEPTH
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [OCC_W-1:0]  off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

FILE: rtl/deque_with_search.sv
// push and refused operations pass through the pending-result register and then the output register;
// a pop adds the POP_WAIT state, a search the SEARCH state (one slot read and compared per cycle)
// one item at a time: a new request is taken only once the last result has entered the output register;
// a search walks the stored words over the slot memory's single read port
// reset: head index, occupancy, sequencer and result valid are cleared; slot memory is not
module deque_with_search
   import dws_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic signed [WORD_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [WORD_W-1:0]   rsp_popped_value,
   output logic                       rsp_found,
   output logic [STATUS_W-1:0]        rsp_status
);

   // slot memory, one write and one registered read port
   logic [WORD_W-1:0]        slot_mem [DEPTH];
   logic [WORD_W-1:0]        rd_data_ff;
   logic                     mem_we;
   logic [ADDR_W-1:0]        wr_addr;
   logic                     rd_en;
   logic [ADDR_W-1:0]        rd_addr;

   // sequencer and ring pointers
   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        head_ff, head_in;
   logic [OCC_W-1:0]         occ_ff, occ_in;
   logic [OCC_W-1:0]         cnt_ff, cnt_in;
   logic [WORD_W-1:0]        key_ff, key_in;

   // pending result, waiting for the output register
   logic [WORD_W-1:0]        res_popped_ff, res_popped_in;
   logic                     res_found_ff, res_found_in;
   status_type               res_status_ff, res_status_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]        rsp_popped_ff, rsp_popped_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   logic                     accept;
   logic                     is_full;
   logic                     is_empty;
   logic                     key_match;
   logic                     rsp_free;
   logic [ADDR_W-1:0]        head_dec;

   assign accept    = req_valid && req_ready;
   assign is_full   = (occ_ff == OCC_W'(DEPTH));
   assign is_empty  = (occ_ff == '0);
   assign key_match = (rd_data_ff == key_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign head_dec  = (head_ff == '0) ? ADDR_W'(DEPTH - 1) : head_ff - ADDR_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_FINISH;
               if ((req_mode == MODE_POP_FRONT || req_mode == MODE_POP_REAR) && !is_empty) begin
                  state_in = ST_POP_WAIT;
               end
               if (req_mode == MODE_SEARCH && !is_empty) begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_POP_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_SEARCH: begin
            // stop on a hit or once every stored word has been compared
            if (key_match || cnt_ff == occ_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      mem_we        = 1'b0;
      wr_addr       = head_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      cnt_in        = cnt_ff;
      key_in        = key_ff;
      res_popped_in = res_popped_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_popped_in = rsp_popped_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_popped_in = '0;
               res_found_in  = 1'b0;
               res_status_in = STATUS_OK;
               cnt_in        = OCC_W'(1);
               key_in        = req_value;
               case (req_mode)
                  MODE_PUSH_FRONT: begin
                     if (is_full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        wr_addr = head_dec;
                        head_in = head_dec;
                        occ_in  = occ_ff + OCC_W'(1);
                     end
                  end
                  MODE_PUSH_REAR: begin
                     if (is_full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        wr_addr = ring_add(head_ff, occ_ff);
                        occ_in  = occ_ff + OCC_W'(1);
                     end
                  end
                  MODE_POP_FRONT: begin
                     if (is_empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = head_ff;
                        head_in = ring_add(head_ff, OCC_W'(1));
                        occ_in  = occ_ff - OCC_W'(1);
                     end
                  end
                  MODE_POP_REAR: begin
                     if (is_empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = ring_add(head_ff, occ_ff - OCC_W'(1));
                        occ_in  = occ_ff - OCC_W'(1);
                     end
                  end
                  MODE_SEARCH: begin
                     // front word read now, compared next cycle
                     if (!is_empty) begin
                        rd_en   = 1'b1;
                        rd_addr = head_ff;
                     end
                  end
                  default: begin
                     // unused modes leave the state alone
                  end
               endcase
            end
         end
         ST_POP_WAIT: begin
            res_popped_in = rd_data_ff;
         end
         ST_SEARCH: begin
            if (key_match) begin
               res_found_in = 1'b1;
            end else if (cnt_ff != occ_ff) begin
               rd_en   = 1'b1;
               rd_addr = ring_add(head_ff, cnt_ff);
               cnt_in  = cnt_ff + OCC_W'(1);
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_popped_in = res_popped_ff;
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase

      rsp_valid        = rsp_valid_ff;
      rsp_popped_value = rsp_popped_ff;
      rsp_found        = rsp_found_ff;
      rsp_status       = rsp_status_ff;
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[wr_addr] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      key_ff        <= key_in;
      res_popped_ff <= res_popped_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

FILE: tb/deque_checker.sv
`timescale 1ns / 1ps

module deque_checker
   import dws_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [WORD_W-1:0] rsp_popped_value,
   input  logic                     rsp_found,
   input  logic [STATUS_W-1:0]      rsp_status,
   output int                       fail_count,
   output int                       pending
);

   typedef struct packed {
      logic signed [WORD_W-1:0] popped_value;
      logic                     found;
      status_type               status;
   } deque_reply_type;

   // shadow of the ring
   logic signed [WORD_W-1:0] ring_words [DEPTH];
   logic [ADDR_W-1:0]        front_slot;
   int unsigned              held;

   deque_reply_type          awaited_replies [$];
   deque_reply_type          oldest;

   initial begin
      fail_count = 0;
      pending    = 0;
      front_slot = '0;
      held       = 0;
   end

   function automatic logic [ADDR_W-1:0] slot_at(input int unsigned offset);
      return ADDR_W'((front_slot + offset) % DEPTH);
   endfunction

   // applies one word to the shadow ring and returns the reply it should give
   function automatic deque_reply_type apply_request(input logic [MODE_W-1:0]        op,
                                                     input logic signed [WORD_W-1:0] word);
      deque_reply_type r;
      r.popped_value = '0;
      r.found        = 1'b0;
      r.status       = STATUS_OK;
      case (op)
         MODE_PUSH_FRONT: begin
            if (held >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               front_slot = slot_at(DEPTH - 1);
               ring_words[front_slot] = word;
               held++;
            end
         end
         MODE_PUSH_REAR: begin
            if (held >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               ring_words[slot_at(held)] = word;
               held++;
            end
         end
         MODE_POP_FRONT: begin
            if (held == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.popped_value = ring_words[front_slot];
               front_slot = slot_at(1);
               held--;
            end
         end
         MODE_POP_REAR: begin
            if (held == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.popped_value = ring_words[slot_at(held - 1)];
               held--;
            end
         end
         MODE_SEARCH: begin
            for (int unsigned k = 0; k < held; k++) begin
               if (ring_words[slot_at(k)] == word) r.found = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            awaited_replies.push_back(apply_request(req_mode, req_value));
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               $display("%0t: reply word with nothing awaited (popped %0d found %0d status %0d)",
                        $time, rsp_popped_value, rsp_found, rsp_status);
               fail_count++;
            end else begin
               oldest = awaited_replies.pop_front();
               if (rsp_popped_value !== oldest.popped_value) begin
                  $display("%0t: popped_value expected %0d got %0d",
                           $time, oldest.popped_value, rsp_popped_value);
                  fail_count++;
               end
               if (rsp_found !== oldest.found) begin
                  $display("%0t: found expected %0d got %0d", $time, oldest.found, rsp_found);
                  fail_count++;
               end
               if (rsp_status !== oldest.status) begin
                  $display("%0t: status expected %0d got %0d", $time, oldest.status, rsp_status);
                  fail_count++;
               end
            end
         end
         pending = awaited_replies.size();
      end
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import dws_pkg::*;

   // phases of the random part: mostly pushes, mostly pops, or an even mix
   localparam int PHASE_FILL  = 0;
   localparam int PHASE_DRAIN = 1;
   localparam int PHASE_MIX   = 2;

   localparam int RANDOM_WORDS = 950;
   localparam int BLOCK_WORDS  = 50;
   localparam int CALM_BLOCK   = 5;     // this block runs with no idling on either side
   localparam int IDLE_PCT     = 15;
   localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up

   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [WORD_W-1:0] WORD_MAX = ~WORD_MIN;
   localparam logic [MODE_W-1:0]        MODE_SPARE_LO = MODE_W'(MODE_SEARCH + 1);
   localparam logic [MODE_W-1:0]        MODE_SPARE_HI = {MODE_W{1'b1}};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [MODE_W-1:0]        req_mode = MODE_PUSH_FRONT;
   logic signed [WORD_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [WORD_W-1:0] rsp_popped_value;
   logic                     rsp_found;
   logic [STATUS_W-1:0]      rsp_status;

   int                       fail_count;
   int                       pending;
   int                       quiet_cycles = 0;
   bit                       calm = 1'b0;

   always #4 clock = ~clock;

   deque_with_search u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status)
   );

   deque_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // result side back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // watchdog: too long without any word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // present one word and hold it until the block takes it;
   // an idle gap lowers valid on one falling edge and raises it on a later one
   task automatic send_word(input logic [MODE_W-1:0] op, input logic signed [WORD_W-1:0] word);
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < 40);
      end
      req_valid <= 1'b1;
      req_mode  <= op;
      req_value <= word;
      do @(posedge clock); while (!req_ready);
   endtask

   // many small values so that searches hit and duplicates occur, some extremes, the rest random
   function automatic logic signed [WORD_W-1:0] draw_value();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return WORD_W'($signed($urandom_range(0, 15)) - 8);
      if (pick == 4) begin
         case ($urandom_range(0, 3))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            default: return '1;
         endcase
      end
      return WORD_W'($urandom);
   endfunction

   function automatic logic [MODE_W-1:0] draw_mode(input int phase);
      int unsigned roll;
      int unsigned push_cut;
      int unsigned pop_cut;
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_FILL:  begin push_cut = 70; pop_cut = 85; end
         PHASE_DRAIN: begin push_cut = 15; pop_cut = 85; end
         default:     begin push_cut = 36; pop_cut = 72; end
      endcase
      if (roll < push_cut) return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
      if (roll < pop_cut)  return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR;
      if (roll < 97)       return MODE_SEARCH;
      // unused operation codes
      return MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store: refused pops, a search with nothing stored, unused codes
      send_word(MODE_POP_FRONT, '0);
      send_word(MODE_POP_REAR, '0);
      send_word(MODE_SEARCH, '0);
      send_word(MODE_SPARE_LO, WORD_MAX);
      send_word(MODE_SPARE_HI, WORD_MIN);

      // extremes at both ends, then searches that hit and miss
      send_word(MODE_PUSH_FRONT, WORD_MIN);
      send_word(MODE_PUSH_REAR, WORD_MAX);
      send_word(MODE_PUSH_REAR, '0);
      send_word(MODE_PUSH_FRONT, '1);
      send_word(MODE_SEARCH, WORD_MAX);
      send_word(MODE_SEARCH, WORD_MIN);
      send_word(MODE_SEARCH, 1);

      // drain from alternate ends, then once more on empty
      send_word(MODE_POP_FRONT, WORD_MAX);
      send_word(MODE_POP_REAR, WORD_MAX);
      send_word(MODE_POP_FRONT, '0);
      send_word(MODE_POP_REAR, '0);
      send_word(MODE_POP_REAR, '1);

      // random part in blocks that mostly push, mostly pop, or mix, in turn;
      // the fill and drain blocks drive the store towards full and empty refusals
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         calm = ((n / BLOCK_WORDS) == CALM_BLOCK);
         send_word(draw_mode((n / BLOCK_WORDS) % 3), draw_value());
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;

      // let every reply come back, then watch for strays
      wait (pending == 0);
      repeat (DEPTH + 8) @(posedge clock);

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
